// ----- design/rmb_pkg.sv -----
// Package with shared types and constants of the raster mosaic blender.
`default_nettype none
package rmb_pkg;

  // Item function codes.
  localparam logic [1:0] FUNC_BLEND = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Overlap rules.
  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_LAST  = 2'd1;
  localparam logic [1:0] MODE_AVG   = 2'd2;
  localparam logic [1:0] MODE_MAX   = 2'd3;

  // Register indexes.
  localparam logic [2:0] REG_BLEND_MODE  = 3'd0;
  localparam logic [2:0] REG_MOSAIC_COLS = 3'd1;
  localparam logic [2:0] REG_MOSAIC_ROWS = 3'd2;
  localparam logic [2:0] REG_COL_OFFSET  = 3'd3;
  localparam logic [2:0] REG_ROW_OFFSET  = 3'd4;
  localparam logic [2:0] REG_SKIP_ENABLE = 3'd5;
  localparam logic [2:0] REG_SKIP_VALUE  = 3'd6;

  // Stored sum width and entry layout {covered, count, value}.
  localparam int SUM_W   = 48;
  localparam int CNT_W   = 8;
  localparam int ENTRY_W = SUM_W + CNT_W + 1;
  // Width of position arithmetic; covers offsets plus pixel index and the size limits.
  localparam int POS_W   = 15;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'd47;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_OUT
  } rmb_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic take_item;
    logic exec;
    logic div_step;
    logic out_load;
  } rmb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic is_read;
    logic need_div;
    logic div_last;
    logic out_free;
  } rmb_stat_t;

endpackage
`default_nettype wire

// ----- design/raster_mosaic_blender.sv -----
// Top level of the raster mosaic blender.
//
// Usage: requests arrive on the in_ stream; in_tuser carries the function (blend, read,
// clear) and in_tdata the pixel and entry fields. Only a read request produces a
// result on the out_ stream. Registers are written on the cfg_ channel, which is
// always ready; write them only while the block is idle.
// Blend and clear requests pass through accept, store read, and execute with the
// write-back before the next ready. A read adds a step that loads the output register.
// A read in average mode with more than one contribution also runs the one-bit-a-cycle
// divider before that load. A new request is not accepted until the last one is
// through, since the read-modify-write of the single-port store allows no overlap.
// After reset the block sweeps the whole store, one entry a cycle, MOSAIC_COLS_MAX
// times MOSAIC_ROWS_MAX entries (262144 at the defaults), and accepts no request
// until done. The output register holds a result while out_tready is low; the next
// request is still accepted, and a following read waits until the register frees.
`default_nettype none
module raster_mosaic_blender #(
  parameter int MOSAIC_COLS_MAX = 512,
  parameter int MOSAIC_ROWS_MAX = 512,
  parameter int VALUE_BITS      = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // Request stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // func
  // pixel_col[11:0], pixel_row[23:12], pixel_value[55:24], entry_col[64:56],
  // entry_row[73:65], zero fill
  input  wire logic [79:0] in_tdata,
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic             out_tuser,  // covered
  output logic [39:0]      out_tdata   // mosaic_value[31:0], contributions[39:32]
);
  import rmb_pkg::*;

  rmb_cmd_t  cmd;
  rmb_stat_t stat;

  assign cfg_ready = 1'b1;

  rmb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rmb_dp #(
    .MOSAIC_COLS_MAX (MOSAIC_COLS_MAX),
    .MOSAIC_ROWS_MAX (MOSAIC_ROWS_MAX),
    .VALUE_BITS      (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_func     (in_tuser),
    .in_data     (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_covered (out_tuser),
    .out_data    (out_tdata),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule
`default_nettype wire

// ----- design/rmb_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module rmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or registered read at one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ----- design/rmb_ctrl.sv -----
// Controller state machine of the raster mosaic blender.
`default_nettype none
module rmb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire rmb_pkg::rmb_stat_t stat,
  output rmb_pkg::rmb_cmd_t      cmd
);
  import rmb_pkg::*;

  rmb_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (stat.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (!stat.is_read) state_nxt = ST_IDLE;
        else if (stat.need_div) state_nxt = ST_DIV;
        else state_nxt = ST_OUT;
      end
      ST_DIV:   if (stat.div_last) state_nxt = ST_OUT;
      ST_OUT:   if (stat.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.take_item = in_tvalid;
      end
      ST_READ:  ;
      ST_EXEC:  cmd.exec = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_OUT:   cmd.out_load = stat.out_free;
      default:  ;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/rmb_dp.sv -----
// Datapath: registers, address mapping, blend arithmetic, divider and output register.
`default_nettype none
module rmb_dp #(
  parameter int MOSAIC_COLS_MAX = 512,
  parameter int MOSAIC_ROWS_MAX = 512,
  parameter int VALUE_BITS      = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic [1:0]         in_func,
  input  wire logic [79:0]        in_data,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic                    out_covered,
  output logic [39:0]             out_data,
  input  wire rmb_pkg::rmb_cmd_t  cmd,
  output rmb_pkg::rmb_stat_t      stat
);
  import rmb_pkg::*;

  localparam int DEPTH = MOSAIC_COLS_MAX * MOSAIC_ROWS_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int SH    = SUM_W - VALUE_BITS;
  localparam int PW    = 2 * POS_W;

  // Configuration registers.
  logic [1:0]        mode_r;
  logic [9:0]        cols_r, rows_r;
  logic [12:0]       coff_r, roff_r;
  logic              skip_en_r;
  logic [31:0]       skip_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_FIRST;
      cols_r     <= 10'd512;
      rows_r     <= 10'd512;
      coff_r     <= '0;
      roff_r     <= '0;
      skip_en_r  <= 1'b0;
      skip_val_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BLEND_MODE:  mode_r     <= cfg_data[1:0];
        REG_MOSAIC_COLS: cols_r     <= cfg_data[9:0];
        REG_MOSAIC_ROWS: rows_r     <= cfg_data[9:0];
        REG_COL_OFFSET:  coff_r     <= cfg_data[12:0];
        REG_ROW_OFFSET:  roff_r     <= cfg_data[12:0];
        REG_SKIP_ENABLE: skip_en_r  <= cfg_data[0];
        REG_SKIP_VALUE:  skip_val_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item latch.
  logic [1:0]  func_r;
  logic [11:0] pcol_r, prow_r;
  logic [31:0] pval_r;
  logic [8:0]  ecol_r, erow_r;

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      func_r <= in_func;
      pcol_r <= in_data[11:0];
      prow_r <= in_data[23:12];
      pval_r <= in_data[55:24];
      ecol_r <= in_data[64:56];
      erow_r <= in_data[73:65];
    end
  end

  // Effective mosaic size.
  logic [POS_W-1:0] lim_c, lim_r;
  assign lim_c = ({5'd0, cols_r} > POS_W'(MOSAIC_COLS_MAX)) ? POS_W'(MOSAIC_COLS_MAX)
                                                          : {5'd0, cols_r};
  assign lim_r = ({5'd0, rows_r} > POS_W'(MOSAIC_ROWS_MAX)) ? POS_W'(MOSAIC_ROWS_MAX)
                                                          : {5'd0, rows_r};

  // Pixel and nodata values, sign-extended from VALUE_BITS.
  logic [SUM_W-1:0] pv48, sk48;
  assign pv48 = SUM_W'($signed({16'd0, pval_r} << SH) >>> SH);
  assign sk48 = SUM_W'($signed({{16{skip_val_r[31]}}, skip_val_r} << SH) >>> SH);

  // Blend position and validity.
  logic signed [POS_W-1:0] oc, orw;
  logic blend_ok;
  assign oc  = $signed({{2{coff_r[12]}}, coff_r}) + $signed({3'd0, pcol_r});
  assign orw = $signed({{2{roff_r[12]}}, roff_r}) + $signed({3'd0, prow_r});
  assign blend_ok = !(skip_en_r && (pv48 == sk48)) &&
                    !oc[POS_W-1] && (oc < $signed(lim_c)) &&
                    !orw[POS_W-1] && (orw < $signed(lim_r));

  // Read or clear position.
  logic entry_ok;
  assign entry_ok = ({6'd0, ecol_r} < lim_c) && ({6'd0, erow_r} < lim_r);

  // Store address: row times the row pitch plus column.
  logic [POS_W-1:0] a_row, a_col;
  logic [PW-1:0]    a_lin;
  logic [AW-1:0]    item_addr;
  assign a_row = (func_r == FUNC_BLEND) ? POS_W'(orw) : {6'd0, erow_r};
  assign a_col = (func_r == FUNC_BLEND) ? POS_W'(oc)  : {6'd0, ecol_r};
  assign a_lin = PW'(a_row) * PW'(MOSAIC_COLS_MAX) + PW'(a_col);
  assign item_addr = a_lin[AW-1:0];

  // Clearing pass after reset.
  logic [AW-1:0] clr_addr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end
  assign stat.clr_last = (clr_addr_r == AW'(DEPTH - 1));

  // Store.
  logic [ENTRY_W-1:0] ram_q, ram_d;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;

  rmb_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_d),
    .rdata (ram_q)
  );

  logic             e_cov;
  logic [CNT_W-1:0] e_cnt;
  logic [SUM_W-1:0] e_val;
  assign e_cov = ram_q[ENTRY_W-1];
  assign e_cnt = ram_q[SUM_W +: CNT_W];
  assign e_val = ram_q[SUM_W-1:0];

  // Blend merge.
  logic [SUM_W:0]     sum49;
  logic [SUM_W-1:0]   sum_sat;
  logic [ENTRY_W-1:0] merged;
  assign sum49 = {e_val[SUM_W-1], e_val} + {pv48[SUM_W-1], pv48};
  assign sum_sat = (sum49[SUM_W] == sum49[SUM_W-1]) ? sum49[SUM_W-1:0]
                 : (sum49[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}});

  always_comb begin
    merged = ram_q;
    if (!e_cov) begin
      merged = {1'b1, CNT_W'(1), pv48};
    end else begin
      case (mode_r)
        MODE_LAST: merged[SUM_W-1:0] = pv48;
        MODE_AVG: begin
          if (e_cnt != {CNT_W{1'b1}}) begin
            merged = {1'b1, e_cnt + 1'b1, sum_sat};
          end
        end
        MODE_MAX: if ($signed(pv48) > $signed(e_val)) merged[SUM_W-1:0] = pv48;
        default: ;
      endcase
    end
  end

  // Store port selection.
  always_comb begin
    ram_addr = item_addr;
    ram_d    = merged;
    ram_we   = 1'b0;
    if (cmd.clr_step) begin
      ram_addr = clr_addr_r;
      ram_d    = '0;
      ram_we   = 1'b1;
    end else if (cmd.exec) begin
      if (func_r == FUNC_BLEND) begin
        ram_we = blend_ok;
      end else if (func_r == FUNC_CLEAR) begin
        ram_d  = '0;
        ram_we = entry_ok;
      end
    end
  end

  // Read result capture.
  logic             hit;
  logic             rd_cov_r;
  logic [CNT_W-1:0] rd_cnt_r;
  logic [31:0]      rd_val_r;
  logic             use_div_r;
  assign hit = entry_ok && e_cov;
  assign stat.is_read = (func_r == FUNC_READ);
  assign stat.need_div = hit && (mode_r == MODE_AVG) && (e_cnt > CNT_W'(1));

  // Iterative restoring divider, one quotient bit a cycle.
  logic [SUM_W-1:0]     q_r;
  logic [CNT_W:0]       rem_r;
  logic [DIV_CNT_W-1:0] it_r;
  logic                 neg_r;
  logic [CNT_W:0]       rem_sh;
  logic                 q_bit;
  logic [SUM_W-1:0]     q_signed;
  assign rem_sh = {rem_r[CNT_W-1:0], q_r[SUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, rd_cnt_r});
  assign stat.div_last = (it_r == DIV_LAST);
  assign q_signed = neg_r ? (~q_r + 1'b1) : q_r;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_cov_r  <= hit;
      rd_cnt_r  <= hit ? e_cnt : '0;
      rd_val_r  <= hit ? e_val[31:0] : '0;
      use_div_r <= stat.need_div;
      neg_r     <= e_val[SUM_W-1];
      q_r       <= e_val[SUM_W-1] ? (~e_val + 1'b1) : e_val;
      rem_r     <= '0;
      it_r      <= '0;
    end else if (cmd.div_step) begin
      q_r   <= {q_r[SUM_W-2:0], q_bit};
      rem_r <= q_bit ? (rem_sh - {1'b0, rd_cnt_r}) : rem_sh;
      it_r  <= it_r + 1'b1;
    end
  end

  // Output register.
  logic        out_valid_r;
  logic        out_cov_r;
  logic [39:0] out_data_r;
  assign stat.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cov_r  <= rd_cov_r;
      out_data_r <= {rd_cnt_r, use_div_r ? q_signed[31:0] : rd_val_r};
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_covered = out_cov_r;
  assign out_data    = out_data_r;

endmodule
`default_nettype wire

// ----- sim/raster_mosaic_blender_test.sv -----
// Self-checking testbench for the raster mosaic blender: directed and random requests.
`timescale 1ns / 1ps
`default_nettype none
module raster_mosaic_blender_test;
  import rmb_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         LIMIT_CYCLES = 3_000_000;
  // Quiet cycles after the last request before a register write (divider plus pipeline).
  localparam int         DRAIN_CYCLES = 100;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_index;
    logic [31:0] reg_data;
    logic [1:0]  func;
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic [31:0] pixel_value;
    logic [8:0]  entry_col;
    logic [8:0]  entry_row;
  } request_t;

  typedef struct {
    logic [31:0] mosaic_value;
    logic        covered;
    logic [7:0]  contributions;
  } mosaic_read_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [79:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        out_tuser;
  logic [39:0] out_tdata;

  raster_mosaic_blender dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the configuration and the mosaic store.
  logic [1:0]    sh_mode = MODE_FIRST;
  int unsigned   sh_cols = 512;
  int unsigned   sh_rows = 512;
  longint        sh_col_off = 0;
  longint        sh_row_off = 0;
  bit            sh_skip_en = 0;
  longint        sh_skip_val = 0;
  longint        sh_value[int];
  int unsigned   sh_count[int];

  request_t      request_queue[$];
  mosaic_read_t  pending_reads[$];
  request_t      cur_req;
  int            errors = 0;
  int            cycles = 0;
  int            quiet = 0;
  int            requests_sent = 0;
  int            reads_seen = 0;
  bit            req_taken = 0;
  bit            cfg_taken = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void write_register(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      REG_BLEND_MODE:  sh_mode = data[1:0];
      REG_MOSAIC_COLS: sh_cols = data[9:0];
      REG_MOSAIC_ROWS: sh_rows = data[9:0];
      REG_COL_OFFSET:  sh_col_off = longint'(signed'(data[12:0]));
      REG_ROW_OFFSET:  sh_row_off = longint'(signed'(data[12:0]));
      REG_SKIP_ENABLE: sh_skip_en = data[0];
      REG_SKIP_VALUE:  sh_skip_val = longint'(signed'(data));
      default: ;
    endcase
  endfunction

  // Applies one request to the shadow store; a read queues its expected result.
  function automatic void blend_or_read(input request_t r);
    int unsigned  lc, lr;
    longint       v, oc, orow, sum;
    int           idx;
    mosaic_read_t res;
    lc = (sh_cols > 512) ? 512 : sh_cols;
    lr = (sh_rows > 512) ? 512 : sh_rows;
    case (r.func)
      FUNC_BLEND: begin
        v = longint'(signed'(r.pixel_value));
        oc = sh_col_off + longint'(r.pixel_col);
        orow = sh_row_off + longint'(r.pixel_row);
        if (!(sh_skip_en && v == sh_skip_val) && oc >= 0 && oc < lc && orow >= 0 &&
            orow < lr) begin
          idx = int'(orow) * 512 + int'(oc);
          if (!sh_value.exists(idx)) begin
            sh_value[idx] = v;
            sh_count[idx] = 1;
          end else begin
            case (sh_mode)
              MODE_LAST: sh_value[idx] = v;
              MODE_MAX:  if (v > sh_value[idx]) sh_value[idx] = v;
              MODE_AVG: begin
                if (sh_count[idx] < 255) begin
                  sum = sh_value[idx] + v;
                  if (sum > 64'sh7FFF_FFFF_FFFF) sum = 64'sh7FFF_FFFF_FFFF;
                  if (sum < -64'sh8000_0000_0000) sum = -64'sh8000_0000_0000;
                  sh_value[idx] = sum;
                  sh_count[idx]++;
                end
              end
              default: ;
            endcase
          end
        end
      end
      FUNC_CLEAR: begin
        idx = int'(r.entry_row) * 512 + int'(r.entry_col);
        if (r.entry_col < lc && r.entry_row < lr && sh_value.exists(idx)) begin
          sh_value.delete(idx);
          sh_count.delete(idx);
        end
      end
      FUNC_READ: begin
        idx = int'(r.entry_row) * 512 + int'(r.entry_col);
        res = '{32'd0, 1'b0, 8'd0};
        if (r.entry_col < lc && r.entry_row < lr && sh_value.exists(idx)) begin
          v = sh_value[idx];
          if (sh_mode == MODE_AVG && sh_count[idx] > 1) v = v / longint'(sh_count[idx]);
          res = '{v[31:0], 1'b1, sh_count[idx][7:0]};
        end
        pending_reads = {pending_reads, res};
      end
      default: ;
    endcase
  endfunction

  // Acceptance, prediction and result checking at the rising edge.
  always @(posedge clk) begin
    mosaic_read_t exp_res;
    cycles++;
    quiet++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end else if (rst_n) begin
      if (in_tvalid && in_tready) begin
        blend_or_read(cur_req);
        req_taken = 1;
        quiet = 0;
      end
      if (cfg_valid && cfg_ready) begin
        write_register(cur_req.reg_index, cur_req.reg_data);
        cfg_taken = 1;
      end
      if (out_tvalid && out_tready) begin
        reads_seen++;
        if (pending_reads.size() == 0) begin
          report($sformatf("unexpected read result %h", out_tdata));
        end else begin
          exp_res = pending_reads.pop_front();
          if (out_tdata[31:0] !== exp_res.mosaic_value)
            report($sformatf("value %h, expected %h", out_tdata[31:0], exp_res.mosaic_value));
          if (out_tuser !== exp_res.covered)
            report($sformatf("covered %b, expected %b", out_tuser, exp_res.covered));
          if (out_tdata[39:32] !== exp_res.contributions)
            report($sformatf("count %0d, expected %0d", out_tdata[39:32],
                             exp_res.contributions));
        end
      end
    end
  end

  // Request driver: one request or register write at a time, changed at the falling edge.
  always @(negedge clk) begin
    bit nx_in_valid, nx_cfg_valid, busy, idle_now;
    nx_in_valid = in_tvalid && !req_taken;
    nx_cfg_valid = cfg_valid && !cfg_taken;
    busy = nx_in_valid || nx_cfg_valid;
    req_taken = 0;
    cfg_taken = 0;
    idle_now = ($urandom_range(0, 99) < 16) && !(requests_sent >= 400 && requests_sent < 550);
    if (rst_n && !busy && request_queue.size() > 0) begin
      if (request_queue[0].is_cfg) begin
        if (pending_reads.size() == 0 && quiet >= DRAIN_CYCLES) begin
          cur_req = request_queue.pop_front();
          cfg_index <= cur_req.reg_index;
          cfg_data <= cur_req.reg_data;
          nx_cfg_valid = 1;
        end
      end else if (!idle_now) begin
        cur_req = request_queue.pop_front();
        requests_sent++;
        in_tuser <= cur_req.func;
        in_tdata <= {6'd0, cur_req.entry_row, cur_req.entry_col, cur_req.pixel_value,
                     cur_req.pixel_row, cur_req.pixel_col};
        nx_in_valid = 1;
      end
    end
    in_tvalid <= nx_in_valid;
    cfg_valid <= nx_cfg_valid;
  end

  // Result sink: random stalls, a calm stretch, and one long hold-off to back the block up.
  always @(negedge clk) begin
    int hold_left;
    bit held_once;
    if (!held_once && reads_seen >= 150) begin
      held_once = 1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (reads_seen >= 60 && reads_seen < 120) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 16);
    end
  end

  task automatic push_cfg(input logic [2:0] idx, input logic [31:0] data);
    request_t r;
    r = '{default: '0};
    r.is_cfg = 1;
    r.reg_index = idx;
    r.reg_data = data;
    request_queue = {request_queue, r};
  endtask

  task automatic set_all(input logic [1:0] mode, input int cols, input int rows,
                         input int coff, input int roff, input bit sen, input int sval);
    push_cfg(REG_BLEND_MODE, 32'(mode));
    push_cfg(REG_MOSAIC_COLS, cols);
    push_cfg(REG_MOSAIC_ROWS, rows);
    push_cfg(REG_COL_OFFSET, coff);
    push_cfg(REG_ROW_OFFSET, roff);
    push_cfg(REG_SKIP_ENABLE, 32'(sen));
    push_cfg(REG_SKIP_VALUE, sval);
  endtask

  task automatic push_req(input logic [1:0] func, input int pc, input int pr, input int pv,
                          input int ec, input int er);
    request_t r;
    r = '{default: '0};
    r.func = func;
    r.pixel_col = 12'(pc);
    r.pixel_row = 12'(pr);
    r.pixel_value = pv;
    r.entry_col = 9'(ec);
    r.entry_row = 9'(er);
    request_queue = {request_queue, r};
  endtask

  function automatic int pick_size();
    case ($urandom_range(0, 9))
      0: return 1;
      1: return 2;
      2: return 512;
      3: return 1023;
      4: return ($urandom_range(0, 19) == 0) ? 0 : 5;
      default: return $urandom_range(3, 12);
    endcase
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(0, 11))
      0: return -4096;
      1: return 4095;
      2: return $urandom();
      default: return $urandom_range(0, 6) - 3;
    endcase
  endfunction

  // Stimulus and end of run.
  initial begin
    int sval, pv, fsel;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, every function, nodata skip and the unused function code.
    set_all(MODE_FIRST, 512, 512, 0, 0, 1, -5);
    push_req(FUNC_BLEND, 0, 0, 7, 0, 0);
    push_req(FUNC_BLEND, 0, 0, 32'h8000_0000, 0, 0);
    push_req(FUNC_READ, 0, 0, 0, 0, 0);
    push_req(FUNC_BLEND, 4095, 4095, 1, 0, 0);
    push_req(FUNC_BLEND, 511, 511, 32'h7FFF_FFFF, 0, 0);
    push_req(FUNC_READ, 0, 0, 0, 511, 511);
    push_req(FUNC_BLEND, 1, 0, -5, 0, 0);
    push_req(FUNC_READ, 0, 0, 0, 1, 0);
    push_req(FUNC_UNUSED, 4095, 4095, -1, 511, 511);
    push_req(FUNC_CLEAR, 0, 0, 0, 0, 0);
    push_req(FUNC_READ, 0, 0, 0, 0, 0);
    push_req(FUNC_READ, 0, 0, 0, 511, 511);
    // Negative offsets at their extreme, a zero-size mosaic, and oversize limits.
    set_all(MODE_MAX, 0, 0, -4096, 4095, 0, 0);
    push_req(FUNC_READ, 0, 0, 0, 0, 0);
    push_req(FUNC_CLEAR, 0, 0, 0, 511, 511);
    set_all(MODE_MAX, 1023, 1023, -4096, -4096, 0, 0);
    push_req(FUNC_BLEND, 4095, 4095, -9, 0, 0);
    push_req(FUNC_BLEND, 4095, 4095, -3, 0, 0);
    push_req(FUNC_READ, 0, 0, 0, 511, 511);
    // Average with a negative sum and truncation toward zero.
    set_all(MODE_AVG, 4, 4, 0, 0, 0, 0);
    push_req(FUNC_BLEND, 2, 2, -7, 0, 0);
    push_req(FUNC_BLEND, 2, 2, 2, 0, 0);
    push_req(FUNC_READ, 0, 0, 0, 2, 2);
    push_req(FUNC_READ, 0, 0, 0, 4, 2);
    // Count saturation: more pixels than the count can hold on one entry.
    for (int i = 0; i < 257; i++) push_req(FUNC_BLEND, 3, 3, i, 0, 0);
    push_req(FUNC_READ, 0, 0, 0, 3, 3);

    // Random phases with small mosaics so that overlaps are frequent.
    for (int ph = 0; ph < 8; ph++) begin
      sval = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 6) - 3 : $urandom();
      set_all(2'($urandom_range(0, 3)), pick_size(), pick_size(), pick_offset(),
              pick_offset(), 1'($urandom_range(0, 1)), sval);
      for (int i = 0; i < 78; i++) begin
        case ($urandom_range(0, 9))
          0: pv = sval;
          1, 2, 3: pv = $urandom_range(0, 6) - 3;
          default: pv = $urandom();
        endcase
        fsel = $urandom_range(0, 99);
        push_req(fsel < 58 ? FUNC_BLEND : fsel < 88 ? FUNC_READ :
                 fsel < 97 ? FUNC_CLEAR : FUNC_UNUSED,
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 12),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 12),
                 pv,
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 12),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 12));
      end
    end

    wait (request_queue.size() == 0 && !in_tvalid && !cfg_valid && pending_reads.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_reads.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
design/rmb_pkg.sv
design/rmb_ram.sv
design/rmb_ctrl.sv
design/rmb_dp.sv
design/raster_mosaic_blender.sv
sim/raster_mosaic_blender_test.sv
